@@ design/xkd_pkg.sv @@
// ----------------------------------------------------------------------------
// xkd_pkg
// Shared types, constants and functions for the keystream word decryptor.
// ----------------------------------------------------------------------------
package xkd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W  = 4;

    localparam logic [WORD_W-1:0] LCG_MUL  = 32'h41C6_4E6D;
    localparam logic [WORD_W-1:0] LCG_ADD  = 32'h0000_3039;
    localparam logic [WORD_W-1:0] KEY_MASK = 32'h7FFF_FFFF;

    // word position that carries the seed, and the saturation point
    localparam logic [IDX_W-1:0] IDX_SEED_WORD = 4'd7;
    localparam logic [IDX_W-1:0] IDX_SAT       = 4'd8;

    // bit of the key that feeds the chain bit
    localparam int unsigned CHAIN_TAP = 18;

    // register index of the seed
    localparam logic REG_SEED = 1'b0;

    // commands from controller to datapath
    typedef struct packed {
        logic       capture;    // hold first word, load seed into the LCG
        logic       seed_step;  // one LCG step into a generator word
        logic [1:0] seed_idx;   // generator word written by seed_step
        logic       process;    // decrypt one word into the output register
        logic       use_hold;   // decrypt the held word, not the input
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;         // output register can take a word this cycle
        logic out_valid;        // output register holds a word
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] rev_bytes(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // xorshift128-style new value (arithmetic right shifts) from the oldest and newest generator words
    function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] u;
        t = d ^ (d << 11);
        u = a ^ WORD_W'($signed(a) >>> 19);
        return u ^ t ^ WORD_W'($signed(t) >>> 8);
    endfunction

endpackage

@@ design/xkd_word_if.sv @@
// ----------------------------------------------------------------------------
// xkd_in_if / xkd_out_if
// Valid/ready word channels for cipher words in and plain words out.
// ----------------------------------------------------------------------------
interface xkd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] cipher_word;
    logic        first_word;
    logic        last_word;

    modport source (output valid, output cipher_word, output first_word,
                    output last_word, input ready);
    modport sink   (input valid, input cipher_word, input first_word,
                    input last_word, output ready);
endinterface

interface xkd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] plain_word;
    logic        last_out;

    modport source (output valid, output plain_word, output last_out, input ready);
    modport sink   (input valid, input plain_word, input last_out, output ready);
endinterface

@@ design/xkd_ctrl.sv @@
// ----------------------------------------------------------------------------
// xkd_ctrl
// Sequences reseeding on a first word and gates word acceptance.
// ----------------------------------------------------------------------------
module xkd_ctrl
    import xkd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_first,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_SEED,
        S_HELD
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       w_accept;

    // accept words only while running and the output can drain
    always_comb begin
        o_in_ready = (r_state == S_RUN) && i_stat.out_free;
        w_accept   = i_in_valid && o_in_ready;

        o_cmd.capture   = w_accept && i_in_first;
        o_cmd.seed_step = (r_state == S_SEED);
        o_cmd.seed_idx  = r_cnt;
        o_cmd.use_hold  = (r_state == S_HELD);
        o_cmd.process   = (w_accept && !i_in_first) ||
                          ((r_state == S_HELD) && i_stat.out_free);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_RUN: begin
                if (o_cmd.capture) begin
                    n_state = S_SEED;
                    n_cnt   = 2'd0;
                end
            end
            S_SEED: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_HELD;
                end
            end
            S_HELD: begin
                if (i_stat.out_free) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ design/xkd_dp.sv @@
// ----------------------------------------------------------------------------
// xkd_dp
// Generator state, LCG seeding unit, word decryption and output register.
// ----------------------------------------------------------------------------
module xkd_dp
    import xkd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [WORD_W-1:0] i_seed,
    input  logic [WORD_W-1:0] i_cipher_word,
    input  logic              i_last_word,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [WORD_W-1:0] o_plain_word,
    output logic              o_last_out
);

    logic [WORD_W-1:0] r_gen [4];
    logic              r_chain;
    logic [IDX_W-1:0]  r_index;
    logic [WORD_W-1:0] r_lcg;
    logic [WORD_W-1:0] r_hold_word;
    logic              r_hold_last;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_plain;
    logic              r_out_last;

    logic [WORD_W-1:0] w_lcg_next;
    logic [WORD_W-1:0] w_gen_next;
    logic [WORD_W-1:0] w_key;
    logic [WORD_W-1:0] w_word;
    logic              w_last;
    logic [WORD_W-1:0] w_plain;

    // one LCG step per cycle while seeding, registered straight after the multiply
    assign w_lcg_next = WORD_W'(r_lcg * LCG_MUL + LCG_ADD);

    // step the generator and decrypt the selected word
    always_comb begin
        w_gen_next = xs_next(r_gen[0], r_gen[3]);
        w_key      = w_gen_next & KEY_MASK;
        w_word     = i_cmd.use_hold ? r_hold_word : i_cipher_word;
        w_last     = i_cmd.use_hold ? r_hold_last : i_last_word;
        w_plain    = w_word ^ w_key ^ {r_chain, {(WORD_W-1){1'b0}}};
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.out_valid = r_out_valid;

    // generator, chain bit, word count and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_gen[i] <= '0;
            end
            r_chain     <= 1'b0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_chain <= 1'b0;
                r_index <= '0;
            end
            if (i_cmd.seed_step) begin
                r_gen[i_cmd.seed_idx] <= w_lcg_next;
            end
            if (i_cmd.process) begin
                r_gen[0] <= w_gen_next;
                r_gen[1] <= r_gen[0];
                r_gen[2] <= r_gen[1];
                r_gen[3] <= r_gen[2];
                r_chain  <= w_key[CHAIN_TAP];
                if (r_index < IDX_SAT) begin
                    r_index <= r_index + IDX_W'(1);
                end
            end
            if (i_cmd.process) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: LCG value, held first word, output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lcg       <= i_seed;
            r_hold_word <= i_cipher_word;
            r_hold_last <= i_last_word;
        end else if (i_cmd.seed_step) begin
            r_lcg <= w_lcg_next;
        end
        if (i_cmd.process) begin
            r_out_plain <= (r_index == IDX_SEED_WORD) ? rev_bytes(i_seed)
                                                       : rev_bytes(w_plain);
            r_out_last  <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_word = r_out_plain;
    assign o_last_out   = r_out_last;

endmodule

@@ design/xorshift_keystream_word_decrypt.sv @@
// A word taken at the input is in the output register in the next cycle.
// A first word loads the seed, four LCG steps run through the single 32x32
// multiplier, then the held word is decrypted; the input is held off meanwhile.
// Throughput: one word per cycle otherwise, while the output can drain.
// Reset (synchronous, active low): generator, chain bit, word count and seed
// clear to zero; the output register empties.
// ----------------------------------------------------------------------------
// xorshift_keystream_word_decrypt
// Xorshift128-style keystream decryptor for 32-bit words with LCG reseeding.
// ----------------------------------------------------------------------------
module xorshift_keystream_word_decrypt
    import xkd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    xkd_in_if.sink      i_word,
    xkd_out_if.source   o_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WORD_W-1:0] r_seed;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic              w_in_ready;
    logic              w_wr;

    // register write on the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (w_wr) begin
            r_seed <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? r_seed : '0;

    xkd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_word.valid),
        .i_in_first (i_word.first_word),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    xkd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_seed        (r_seed),
        .i_cipher_word (i_word.cipher_word),
        .i_last_word   (i_word.last_word),
        .i_out_ready   (o_word.ready),
        .o_out_valid   (o_word.valid),
        .o_plain_word  (o_word.plain_word),
        .o_last_out    (o_word.last_out)
    );

    assign i_word.ready = w_in_ready;

    // no word is taken while the generator is being seeded
    a_no_accept_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.seed_step |-> !w_in_ready)
        else $error("word taken during seeding");

    // a first word always starts a seeding run
    a_first_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_word.valid && w_in_ready && i_word.first_word) |=> w_cmd.seed_step)
        else $error("first word did not start seeding");

    // a decrypted word never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.process && w_stat.out_valid) |-> o_word.ready)
        else $error("output word overwritten");

    // seeding ends with the held word selected for decryption
    a_seed_then_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.seed_step && w_cmd.seed_idx == 2'd3) |=> w_cmd.use_hold)
        else $error("held word not processed after seeding");

endmodule
